>>> design/mtm_pkg.sv
// ----------------------------------------------------------------------------
// mtm_pkg: shared types and codes for the message tag matcher
// Status codes, event kinds, register indexes and the queue cell entry type.
// ----------------------------------------------------------------------------
package mtm_pkg;

    localparam logic [1:0] KIND_ARRIVAL = 2'd0;
    localparam logic [1:0] KIND_RECV    = 2'd1;
    localparam logic [1:0] KIND_FINISH  = 2'd2;

    localparam logic [3:0] ST_DELIVERED = 4'd0;
    localparam logic [3:0] ST_QUEUED    = 4'd1;
    localparam logic [3:0] ST_DROPPED   = 4'd2;
    localparam logic [3:0] ST_SERVED    = 4'd3;
    localparam logic [3:0] ST_PENDING   = 4'd4;
    localparam logic [3:0] ST_REMOTE    = 4'd5;
    localparam logic [3:0] ST_SELF      = 4'd6;
    localparam logic [3:0] ST_NO_RANK   = 4'd7;
    localparam logic [3:0] ST_BUSY      = 4'd8;
    localparam logic [3:0] ST_FIN_NOTED = 4'd9;
    localparam logic [3:0] ST_PEND_FAIL = 4'd10;

    localparam logic [0:0] REG_WORLD_SIZE = 1'd0;
    localparam logic [0:0] REG_OWN_RANK   = 1'd1;

    localparam int SRC_W = 4;
    localparam int TAG_W = 32;
    localparam int CNT_W = 31;

    // rank limit; ranks must fit the SRC_W-bit source field
    localparam int MAX_RANKS = 16;

    // Search key broadcast along the cell row
    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [TAG_W-1:0] tag;
        logic [CNT_W-1:0] cnt;
    } key_t;

    // Per-cycle command to every cell
    typedef struct packed {
        logic load;   // append arrival at the first free cell
        logic pop;    // remove the matched cell, younger cells shift down
    } cell_cmd_t;

endpackage

>>> design/mtm_cell.sv
// ----------------------------------------------------------------------------
// mtm_cell: one slot of the unexpected queue
// Holds one descriptor, compares it to the search key, and shifts toward the
// head when an older slot is popped.
// ----------------------------------------------------------------------------
module mtm_cell #(
    parameter int HW = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mtm_pkg::cell_cmd_t   cmd,
    input  mtm_pkg::key_t        key,
    input  mtm_pkg::key_t        new_entry,
    input  logic [HW-1:0]        new_handle,
    input  logic                 first_free,   // this is the first free cell
    input  logic                 sel_below,    // pop point is at or below this cell
    input  logic                 up_valid,
    input  mtm_pkg::key_t        up_entry,
    input  logic [HW-1:0]        up_handle,
    output logic                 valid,
    output mtm_pkg::key_t        entry,
    output logic [HW-1:0]        handle,
    output logic                 hit
);

    logic               valid_reg, valid_next;
    mtm_pkg::key_t      entry_reg, entry_next;
    logic [HW-1:0]      handle_reg, handle_next;

    assign valid  = valid_reg;
    assign entry  = entry_reg;
    assign handle = handle_reg;
    // request key: tag 0 is a wildcard
    assign hit = valid_reg && entry_reg.src == key.src && entry_reg.cnt == key.cnt
                 && (entry_reg.tag == key.tag || key.tag == '0);

    always_comb
    begin
        valid_next  = valid_reg;
        entry_next  = entry_reg;
        handle_next = handle_reg;
        if (cmd.load && first_free)
        begin
            valid_next  = 1'b1;
            entry_next  = new_entry;
            handle_next = new_handle;
        end
        else if (cmd.pop && sel_below)
        begin
            valid_next  = up_valid;
            entry_next  = up_entry;
            handle_next = up_handle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg  <= entry_next;
        handle_reg <= handle_next;
    end

endmodule

>>> design/message_tag_matcher.sv
// Flow: each input transaction is compared, then answered; no new transaction
//   is taken while one is held; the cell row compares all slots
//   and pops or appends in the cycle after accept, and the result register
//   shows the answer in the next; a stalled result holds off the input.
// Reset: asynchronous, active low; clears pending receive, finish flags and
//   slot valid bits at once, no clearing pass.
// ----------------------------------------------------------------------------
// message_tag_matcher: receive matching against an unexpected queue
// Single pending receive plus a row of queue cells kept packed oldest first.
// ----------------------------------------------------------------------------
module message_tag_matcher #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int HANDLE_WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [0:0]               cfg_index,
    input  logic [4:0]               cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               kind,
    input  logic signed [7:0]        peer_rank,
    input  logic signed [31:0]       msg_tag,
    input  logic [30:0]              byte_count,
    input  logic [HANDLE_WIDTH-1:0]  msg_handle,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [3:0]               status,
    output logic [HANDLE_WIDTH-1:0]  out_handle,
    output logic [3:0]               out_source,
    output logic signed [31:0]       out_tag,
    output logic [30:0]              out_count
);

    localparam int QD = QUEUE_DEPTH;
    localparam int QI = (QD > 1) ? $clog2(QD) : 1;

    logic [4:0]  world_reg;
    logic [3:0]  own_reg;

    // stage 1: accepted transaction held while the cells compare
    logic                     busy_reg;
    logic [1:0]               kind_reg;
    logic [7:0]               peer_reg;
    mtm_pkg::key_t            key_reg;
    logic [HANDLE_WIDTH-1:0]  hnd_reg;

    logic                             waiting_reg;
    mtm_pkg::key_t                    want_reg;
    logic [mtm_pkg::MAX_RANKS-1:0]    done_reg;

    logic                     ov_reg;
    logic [3:0]               st_reg;
    logic [HANDLE_WIDTH-1:0]  oh_reg;
    mtm_pkg::key_t            oe_reg;

    logic accept;
    assign in_stall = busy_reg || (ov_reg && out_stall);
    assign accept   = in_valid && !in_stall && kind != 2'd3;

    logic [QD-1:0]            v, hits, below, first_free;
    mtm_pkg::key_t            ent [QD];
    logic [HANDLE_WIDTH-1:0]  hd  [QD];
    mtm_pkg::cell_cmd_t       cmd;

    // prefix scans: at most one hit chosen, oldest first
    logic [QD-1:0] hit_seen;
    always_comb
    begin
        for (int i = 0; i < QD; i++)
        begin
            hit_seen[i] = hits[i] || (i > 0 && hit_seen[(i > 0) ? i-1 : 0]);
            first_free[i] = !v[i] && (i == 0 || v[(i > 0) ? i-1 : 0]);
        end
        below = hit_seen;
    end

    logic [QI-1:0] hit_idx;
    always_comb
    begin
        hit_idx = '0;
        for (int i = QD-1; i >= 0; i--)
            if (hits[i]) hit_idx = QI'(i);
    end

    genvar g;
    generate
        for (g = 0; g < QD; g++)
        begin : g_cell
            mtm_cell #(.HW(HANDLE_WIDTH)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .key        (key_reg),
                .new_entry  (key_reg),
                .new_handle (hnd_reg),
                .first_free (first_free[g]),
                .sel_below  (below[g]),
                .up_valid   ((g < QD-1) ? v[(g < QD-1) ? g+1 : g] : 1'b0),
                .up_entry   (ent[(g < QD-1) ? g+1 : g]),
                .up_handle  (hd[(g < QD-1) ? g+1 : g]),
                .valid      (v[g]),
                .entry      (ent[g]),
                .handle     (hd[g]),
                .hit        (hits[g])
            );
        end
    endgenerate

    // stage 2 decision
    logic                         peer_neg, is_self, no_rank, fits_want, done_src;
    logic [3:0]                   st_next;
    logic                         wait_set, wait_clr, set_done;
    assign peer_neg  = peer_reg[7];
    assign is_self   = !peer_neg && peer_reg == {4'd0, own_reg};
    assign no_rank   = peer_neg || {1'b0, peer_reg} >= {4'd0, world_reg}
                       || 9'(peer_reg) >= 9'(mtm_pkg::MAX_RANKS);
    assign fits_want = waiting_reg && want_reg.src == key_reg.src
                       && want_reg.cnt == key_reg.cnt
                       && (want_reg.tag == key_reg.tag || want_reg.tag == '0);
    assign done_src  = done_reg[key_reg.src];

    always_comb
    begin
        st_next  = mtm_pkg::ST_NO_RANK;
        cmd      = '0;
        wait_set = 1'b0;
        wait_clr = 1'b0;
        set_done = 1'b0;
        if (busy_reg)
        begin
            if (is_self) st_next = mtm_pkg::ST_SELF;
            else if (no_rank) st_next = mtm_pkg::ST_NO_RANK;
            else
            begin
                case (kind_reg)
                    mtm_pkg::KIND_ARRIVAL:
                    begin
                        if (fits_want)
                        begin
                            st_next  = mtm_pkg::ST_DELIVERED;
                            wait_clr = 1'b1;
                        end
                        else if (v[QD-1]) st_next = mtm_pkg::ST_DROPPED;
                        else
                        begin
                            st_next  = mtm_pkg::ST_QUEUED;
                            cmd.load = 1'b1;
                        end
                    end
                    mtm_pkg::KIND_RECV:
                    begin
                        if (waiting_reg) st_next = mtm_pkg::ST_BUSY;
                        else if (|hits)
                        begin
                            st_next = mtm_pkg::ST_SERVED;
                            cmd.pop = 1'b1;
                        end
                        else if (done_src) st_next = mtm_pkg::ST_REMOTE;
                        else
                        begin
                            st_next  = mtm_pkg::ST_PENDING;
                            wait_set = 1'b1;
                        end
                    end
                    default:
                    begin
                        set_done = 1'b1;
                        if (waiting_reg && want_reg.src == key_reg.src)
                        begin
                            st_next  = mtm_pkg::ST_PEND_FAIL;
                            wait_clr = 1'b1;
                        end
                        else st_next = mtm_pkg::ST_FIN_NOTED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_reg   <= 5'd1;
            own_reg     <= 4'd0;
            busy_reg    <= 1'b0;
            waiting_reg <= 1'b0;
            done_reg    <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == mtm_pkg::REG_WORLD_SIZE) world_reg <= cfg_data;
            if (cfg_we && cfg_index == mtm_pkg::REG_OWN_RANK) own_reg <= cfg_data[3:0];
            busy_reg <= accept;
            if (wait_set) waiting_reg <= 1'b1;
            else if (wait_clr) waiting_reg <= 1'b0;
            if (set_done) done_reg[key_reg.src] <= 1'b1;
            if (busy_reg) ov_reg <= 1'b1;
            else if (!out_stall) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind;
            peer_reg    <= peer_rank;
            key_reg.src <= peer_rank[3:0];
            key_reg.tag <= msg_tag;
            key_reg.cnt <= byte_count;
            hnd_reg     <= msg_handle;
        end
        if (wait_set) want_reg <= key_reg;
        if (busy_reg)
        begin
            st_reg <= st_next;
            if (st_next == mtm_pkg::ST_DELIVERED)
            begin
                oh_reg <= hnd_reg;
                oe_reg <= key_reg;
            end
            else if (st_next == mtm_pkg::ST_SERVED)
            begin
                oh_reg <= hd[hit_idx];
                oe_reg <= ent[hit_idx];
            end
            else
            begin
                oh_reg <= '0;
                oe_reg <= '0;
            end
        end
    end

    assign out_valid  = ov_reg;
    assign status     = st_reg;
    assign out_handle = oh_reg;
    assign out_source = oe_reg.src;
    assign out_tag    = oe_reg.tag;
    assign out_count  = oe_reg.cnt;

`ifndef SYNTHESIS
    a_one_hit_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> $onehot(below & ~(below << 1)))
        else $error("pop point not unique");
    a_no_load_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !v[QD-1])
        else $error("append into full queue");
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> out_valid)
        else $error("result missing");
    a_no_load_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.pop))
        else $error("append and pop together");
`endif

endmodule

>>> verif/mtm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_checker: result predictor and scoreboard for message_tag_matcher
// Watches the input, output and register ports, keeps its own copy of the
// matcher state, and compares each result transaction with the oldest
// predicted result, field by field.
// ----------------------------------------------------------------------------
module mtm_checker
    import mtm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [4:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         kind,
    input  logic signed [7:0]  peer_rank,
    input  logic signed [31:0] msg_tag,
    input  logic [30:0]        byte_count,
    input  logic [7:0]         msg_handle,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [3:0]         status,
    input  logic [7:0]         out_handle,
    input  logic [3:0]         out_source,
    input  logic signed [31:0] out_tag,
    input  logic [30:0]        out_count,
    output int                 fail_count,
    output int                 pending_results
);

    localparam int DEPTH = 16;
    localparam int RANKS = 16;

    typedef struct packed {
        logic [3:0]  st;
        logic [7:0]  hnd;
        logic [3:0]  src;
        logic [31:0] tag;
        logic [30:0] cnt;
    } answer_t;

    typedef struct packed {
        logic [3:0]  src;
        logic [31:0] tag;
        logic [30:0] cnt;
        logic [7:0]  hnd;
    } slot_t;

    answer_t answer_q[$];
    slot_t   unexp_q[$];
    logic [4:0]  world;
    logic [3:0]  self_rank;
    logic        pend_open;
    logic [3:0]  pend_src;
    logic [31:0] pend_tag;
    logic [30:0] pend_cnt;
    logic [RANKS-1:0] done_flags;

    function automatic answer_t plain(logic [3:0] st);
        answer_t a;
        a = '0;
        a.st = st;
        return a;
    endfunction

    task automatic predict_event(input logic [1:0] k, input logic signed [7:0] pr,
                                 input logic [31:0] tg, input logic [30:0] cn,
                                 input logic [7:0] hd);
        answer_t a;
        logic [3:0] src;
        int hit;
        hit = -1;
        if (k == 2'd3)
            return;
        if (pr >= 0 && pr[3:0] == self_rank && pr < 16)
        begin
            answer_q.push_back(plain(ST_SELF));
            return;
        end
        if (pr < 0 || pr >= $signed({3'b000, world}) || pr >= RANKS)
        begin
            answer_q.push_back(plain(ST_NO_RANK));
            return;
        end
        src = pr[3:0];
        if (k == KIND_ARRIVAL)
        begin
            if (pend_open && cn == pend_cnt && src == pend_src &&
                (tg == pend_tag || pend_tag == 0))
            begin
                pend_open = 1'b0;
                a.st = ST_DELIVERED; a.hnd = hd; a.src = src; a.tag = tg; a.cnt = cn;
                answer_q.push_back(a);
            end
            else if (unexp_q.size() < DEPTH)
            begin
                unexp_q.push_back('{src, tg, cn, hd});
                answer_q.push_back(plain(ST_QUEUED));
            end
            else
                answer_q.push_back(plain(ST_DROPPED));
        end
        else if (k == KIND_RECV)
        begin
            if (pend_open)
            begin
                answer_q.push_back(plain(ST_BUSY));
                return;
            end
            foreach (unexp_q[i])
                if (hit < 0 && unexp_q[i].cnt == cn && unexp_q[i].src == src &&
                    (unexp_q[i].tag == tg || tg == 0))
                    hit = i;
            if (hit >= 0)
            begin
                a.st = ST_SERVED; a.hnd = unexp_q[hit].hnd; a.src = unexp_q[hit].src;
                a.tag = unexp_q[hit].tag; a.cnt = unexp_q[hit].cnt;
                unexp_q.delete(hit);
                answer_q.push_back(a);
            end
            else if (done_flags[src])
                answer_q.push_back(plain(ST_REMOTE));
            else
            begin
                pend_open = 1'b1; pend_src = src; pend_tag = tg; pend_cnt = cn;
                answer_q.push_back(plain(ST_PENDING));
            end
        end
        else
        begin
            done_flags[src] = 1'b1;
            if (pend_open && pend_src == src)
            begin
                pend_open = 1'b0;
                answer_q.push_back(plain(ST_PEND_FAIL));
            end
            else
                answer_q.push_back(plain(ST_FIN_NOTED));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t exp_a;
        int errs;
        if (!rst_n)
        begin
            answer_q.delete();
            unexp_q.delete();
            world <= 5'd1;
            self_rank <= 4'd0;
            pend_open = 1'b0;
            pend_src = '0; pend_tag = '0; pend_cnt = '0;
            done_flags = '0;
            fail_count <= 0;
            pending_results <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_we)
            begin
                if (cfg_index == REG_WORLD_SIZE)
                    world <= cfg_data;
                else
                    self_rank <= cfg_data[3:0];
            end
            if (out_valid && !out_stall)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("unexpected result transaction, status %0d", status);
                    errs++;
                end
                else
                begin
                    exp_a = answer_q.pop_front();
                    if (status !== exp_a.st)
                    begin
                        $error("status: expected %0d actual %0d", exp_a.st, status);
                        errs++;
                    end
                    if (out_handle !== exp_a.hnd)
                    begin
                        $error("out_handle: expected %0d actual %0d", exp_a.hnd, out_handle);
                        errs++;
                    end
                    if (out_source !== exp_a.src)
                    begin
                        $error("out_source: expected %0d actual %0d", exp_a.src, out_source);
                        errs++;
                    end
                    if (out_tag !== exp_a.tag)
                    begin
                        $error("out_tag: expected %0h actual %0h", exp_a.tag, out_tag);
                        errs++;
                    end
                    if (out_count !== exp_a.cnt)
                    begin
                        $error("out_count: expected %0h actual %0h", exp_a.cnt, out_count);
                        errs++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_event(kind, peer_rank, msg_tag, byte_count, msg_handle);
            fail_count <= fail_count + errs;
            pending_results <= answer_q.size();
        end
    end

endmodule

>>> verif/tb_message_tag_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_message_tag_matcher: stimulus and verdict for message_tag_matcher
// Directed corner events, then random phases of arrival/receive/finish
// traffic over several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_message_tag_matcher;
    import mtm_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [4:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  kind = '0;
    logic signed [7:0]  peer_rank = '0;
    logic signed [31:0] msg_tag = '0;
    logic [30:0] byte_count = '0;
    logic [7:0]  msg_handle = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  status;
    logic [7:0]  out_handle;
    logic [3:0]  out_source;
    logic signed [31:0] out_tag;
    logic [30:0] out_count;
    int          fail_count;
    int          pending_results;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;
    logic [4:0]  world_now = 5'd1;
    logic [3:0]  self_now = 4'd0;

    always #2 clk = ~clk;

    message_tag_matcher i_dut (.*);

    mtm_checker i_chk (.*);

    // receiver side stall
    always @(posedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 35);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("** message_tag_matcher: FAILED **");
            $finish;
        end
    end

    // valid stays high after the transaction; the next call or a drain drops it
    task automatic send_event(input logic [1:0] k, input logic signed [7:0] pr,
                              input logic [31:0] tg, input logic [30:0] cn,
                              input logic [7:0] hd);
        if (!calm && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 35)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k; peer_rank <= pr; msg_tag <= tg; byte_count <= cn; msg_handle <= hd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [4:0] val);
        drain_results();
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WORLD_SIZE) world_now = val; else self_now = val[3:0];
    endtask

    // mostly valid ranks, sometimes anything
    function automatic logic [7:0] pick_rank();
        if ($urandom_range(9) == 0)
            return 8'($urandom);
        return 8'($urandom_range((world_now == 0) ? 0 : world_now - 1));
    endfunction

    task automatic random_phase(input int n);
        logic [7:0]  pr;
        logic [31:0] tg;
        logic [30:0] cn;
        int r;
        for (int i = 0; i < n; i++)
        begin
            pr = pick_rank();
            r = $urandom_range(99);
            tg = ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(3));
            cn = ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom_range(2));
            if (r < 45)
                send_event(KIND_ARRIVAL, pr, tg, cn, 8'($urandom));
            else if (r < 88)
                send_event(KIND_RECV, pr, tg, cn, 8'($urandom));
            else if (r < 97)
                send_event(KIND_FINISH, pr, tg, cn, 8'($urandom));
            else
                send_event(2'd3, pr, tg, cn, 8'($urandom));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // defaults: world 1, self 0 -> everything self or no rank
        send_event(KIND_ARRIVAL, 8'sd0, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 8'hFF);
        send_event(KIND_RECV, 8'sd1, 32'h8000_0000, 31'd0, 8'h00);
        write_reg(REG_WORLD_SIZE, 5'd16);
        write_reg(REG_OWN_RANK, 5'd15);
        send_event(KIND_ARRIVAL, -8'sd128, 32'd5, 31'd1, 8'd1);
        send_event(KIND_ARRIVAL, 8'sd127, 32'd5, 31'd1, 8'd1);
        send_event(KIND_ARRIVAL, 8'sd15, 32'd5, 31'd1, 8'd1);
        send_event(KIND_RECV, 8'sd3, 32'd0, 31'd9, 8'd0);       // pending, any tag
        send_event(KIND_RECV, 8'sd3, 32'd1, 31'd9, 8'd0);       // busy
        send_event(KIND_ARRIVAL, 8'sd3, 32'hDEAD_BEEF, 31'd9, 8'hA5); // delivered
        for (int i = 0; i < 17; i++)  // fill then drop
            send_event(KIND_ARRIVAL, 8'(i % 15), 32'(i), 31'(i), 8'(i));
        send_event(KIND_RECV, 8'sd2, 32'd0, 31'd2, 8'd0);        // served
        send_event(KIND_FINISH, 8'sd14, 32'd0, 31'd0, 8'd0);
        send_event(KIND_FINISH, 8'sd14, 32'd0, 31'd0, 8'd0);     // repeated
        send_event(KIND_RECV, 8'sd14, 32'd7, 31'd7, 8'd0);       // remote finished
        send_event(KIND_RECV, 8'sd13, 32'd7, 31'd7, 8'd0);       // pending
        send_event(KIND_FINISH, 8'sd13, 32'd0, 31'd0, 8'd0);     // pending failed
        send_event(2'd3, 8'sd1, 32'd0, 31'd0, 8'd0);
        // receives against the leftovers; rank 2 has none left and goes pending, so the later ranks see busy
        for (int i = 0; i < 15; i++)
            send_event(KIND_RECV, 8'(i), 32'd0, 31'(i), 8'd0);

        write_reg(REG_WORLD_SIZE, 5'd4);
        write_reg(REG_OWN_RANK, 5'd0);
        random_phase(400);
        write_reg(REG_WORLD_SIZE, 5'd31);
        write_reg(REG_OWN_RANK, 5'd7);
        calm = 1'b1;
        random_phase(300);
        calm = 1'b0;
        write_reg(REG_WORLD_SIZE, 5'd2);
        write_reg(REG_OWN_RANK, 5'd1);
        random_phase(350);
        write_reg(REG_WORLD_SIZE, 5'd16);
        write_reg(REG_OWN_RANK, 5'd3);
        random_phase(450);
        write_reg(REG_WORLD_SIZE, 5'd0);
        random_phase(50);
        write_reg(REG_WORLD_SIZE, 5'd9);
        write_reg(REG_OWN_RANK, 5'd15);
        random_phase(400);

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("** message_tag_matcher: PASSED **");
        else
            $display("** message_tag_matcher: FAILED **");
        $finish;
    end

endmodule
